FILE: rtl/brrip_pkg.sv
// ----------------------------------------------------------------------------
// brrip_pkg
// Shared field widths, register indexes, RRPV codes and the command/status
// structs that pass between the BRRIP controller and datapath.
// ----------------------------------------------------------------------------
package brrip_pkg;

  // word field widths
  localparam int SET_IN_W  = 10;
  localparam int TAG_IN_W  = 20;
  localparam int WAY_OUT_W = 2;
  localparam int IN_DATA_W  = 32;  // set_index + tag_value, padded to bytes
  localparam int OUT_DATA_W = 24;  // hit + way + evicted + evicted_tag

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int WAYS_REG_W = 3;
  localparam int PERIOD_W   = 11;
  localparam int ICNT_W     = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WAYS    = 1'b0,
    CFG_BIMODAL_PERIOD = 1'b1
  } cfg_idx_t;

  localparam logic [WAYS_REG_W-1:0] ACTIVE_WAYS_RST    = 3'd4;
  localparam logic [PERIOD_W-1:0]   BIMODAL_PERIOD_RST = 11'd8;
  localparam logic [PERIOD_W-1:0]   MAX_PERIOD         = 11'd1024;

  // re-reference prediction values
  localparam int RRPV_W = 2;
  localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
  localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic clr_we;   // write reset row at sweep index
    logic capture;  // latch accepted word
    logic rd_en;    // read the addressed set
    logic upd_go;   // write back set, load result register
  } brrip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep at final row
  } brrip_stat_t;

endpackage

FILE: rtl/brrip_ctrl.sv
// ----------------------------------------------------------------------------
// brrip_ctrl
// Sequencer: reset sweep, accept, set read, update/result, output valid.
// ----------------------------------------------------------------------------
module brrip_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  brrip_pkg::brrip_stat_t stat,
  output brrip_pkg::brrip_cmd_t  cmd
);
  import brrip_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RD   = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   go;

  assign go = (state_r == ST_UPD) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_go = go;
        if (go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (go)         out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // accepted word walks read then update
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RD) ##1 (state_r == ST_UPD))
    else $error("accepted word did not go to set read then update");

  // sweep and update never share the write port
  a_wport: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_we && (cmd.upd_go || cmd.rd_en || cmd.capture)))
    else $error("sweep overlaps an access");

  // an update always leaves a result pending
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_go |=> out_valid_r)
    else $error("update produced no result");

  // update never overwrites an untaken result
  a_noovr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_go |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

endmodule

FILE: rtl/brrip_dp.sv
// ----------------------------------------------------------------------------
// brrip_dp
// Set memories, set-index reduction, hit/fill/age/victim logic, insert
// counter, configuration registers and result register.
// ----------------------------------------------------------------------------
module brrip_dp #(
  parameter int SETS     = 1024,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  brrip_pkg::brrip_cmd_t                cmd,
  output brrip_pkg::brrip_stat_t               stat,
  input  logic [brrip_pkg::SET_IN_W-1:0]       set_index,
  input  logic [brrip_pkg::TAG_IN_W-1:0]       tag_value,
  input  logic                                 cfg_wr_en,
  input  logic [brrip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brrip_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                 hit,
  output logic [brrip_pkg::WAY_OUT_W-1:0]      way,
  output logic                                 evicted,
  output logic [brrip_pkg::TAG_IN_W-1:0]       evicted_tag
);
  import brrip_pkg::*;

  localparam int TW     = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);
  localparam int RSH    = 2 * SET_IN_W;
  // floor reciprocal of SETS; quotient comes out exact or one low
  localparam int RECIP  = (1 << RSH) / SETS;
  localparam int SET_P_W = SET_IN_W + 1;

  // configuration
  logic [WAYS_REG_W-1:0] act_ways_r;
  logic [PERIOD_W-1:0]   period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_ways_r <= ACTIVE_WAYS_RST;
      period_r   <= BIMODAL_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_WAYS:    act_ways_r <= cfg_wdata[WAYS_REG_W-1:0];
        CFG_BIMODAL_PERIOD: period_r   <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture, quotient estimate for set reduction
  logic [SET_IN_W-1:0] set_raw_r;
  logic [SET_IN_W-1:0] quo_r;
  logic [TW-1:0]       tag_r;
  logic [SET_W-1:0]    set_r;
  logic [31:0]         quo_full;

  assign quo_full = (32'(set_index) * 32'(RECIP)) >> RSH;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_raw_r <= set_index;
      quo_r     <= quo_full[SET_IN_W-1:0];
      tag_r     <= tag_value[TW-1:0];
    end
  end

  logic [31:0]        prod;
  logic [SET_P_W-1:0] rem0, rem1;
  logic [SET_W-1:0]   rd_set;

  always_comb begin
    prod = 32'(quo_r) * 32'(SETS);
    rem0 = SET_P_W'({1'b0, set_raw_r}) - prod[SET_P_W-1:0];
    rem1 = (32'(rem0) >= 32'(SETS)) ? rem0 - SET_P_W'(SETS) : rem0;
    rd_set = SET_W'(32'(rem1));
  end

  // set memories
  logic [WAYS-1:0]              vld_mem  [SETS];
  logic [WAYS-1:0][RRPV_W-1:0]  rrpv_mem [SETS];
  logic [WAYS-1:0][TW-1:0]      tag_mem  [SETS];

  logic [WAYS-1:0]              vld_q;
  logic [WAYS-1:0][RRPV_W-1:0]  rrpv_q;
  logic [WAYS-1:0][TW-1:0]      tag_q;

  logic [WAYS-1:0]              vld_new;
  logic [WAYS-1:0][RRPV_W-1:0]  rrpv_new;
  logic [WAYS-1:0][TW-1:0]      tag_new;

  logic [SET_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_we) begin
      clr_idx_r <= clr_idx_r + SET_W'(1);
    end
  end

  assign stat.clr_last = (clr_idx_r == SET_W'(SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      vld_mem[clr_idx_r]  <= '0;
      rrpv_mem[clr_idx_r] <= {WAYS{RRPV_DISTANT}};
    end else if (cmd.upd_go) begin
      vld_mem[set_r]  <= vld_new;
      rrpv_mem[set_r] <= rrpv_new;
      tag_mem[set_r]  <= tag_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      vld_q  <= vld_mem[rd_set];
      rrpv_q <= rrpv_mem[rd_set];
      tag_q  <= tag_mem[rd_set];
      set_r  <= rd_set;
    end
  end

  // effective ways and period
  logic [WCNT_W-1:0]   ways_eff;
  logic [PERIOD_W-1:0] period_eff;

  always_comb begin
    if (act_ways_r == '0)                 ways_eff = WCNT_W'(1);
    else if (32'(act_ways_r) > 32'(WAYS)) ways_eff = WCNT_W'(WAYS);
    else                                  ways_eff = WCNT_W'(32'(act_ways_r));
    if (period_r == '0)                   period_eff = PERIOD_W'(1);
    else if (period_r > MAX_PERIOD)       period_eff = MAX_PERIOD;
    else                                  period_eff = period_r;
  end

  // insert counter
  logic [ICNT_W-1:0]   icnt_r, icnt_nxt;
  logic [PERIOD_W-1:0] icnt_inc;
  logic [RRPV_W-1:0]   ins_rrpv;

  always_comb begin
    icnt_inc = PERIOD_W'(icnt_r) + PERIOD_W'(1);
    icnt_nxt = (icnt_inc >= period_eff) ? '0 : icnt_inc[ICNT_W-1:0];
    ins_rrpv = (icnt_r == '0) ? RRPV_LONG : RRPV_DISTANT;
  end

  // lookup, fill, aging, victim
  logic [WAYS-1:0]             act, hitv, invv, distv;
  logic [WAYS-1:0][RRPV_W-1:0] aged;
  logic [WAY_W-1:0]            hit_way, inv_way, dist_way, vic;
  logic                        any_hit, any_inv, any3, any2, any1;
  logic [RRPV_W-1:0]           maxr, add;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      act[w]  = 32'(w) < 32'(ways_eff);
      hitv[w] = act[w] && vld_q[w] && (tag_q[w] == tag_r);
      invv[w] = act[w] && !vld_q[w];
    end
    any_hit = |hitv;
    any_inv = |invv;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      any3 |= act[w] && (rrpv_q[w] == 2'd3);
      any2 |= act[w] && (rrpv_q[w] == 2'd2);
      any1 |= act[w] && (rrpv_q[w] == 2'd1);
    end
    maxr = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    add  = RRPV_DISTANT - maxr;
    for (int w = 0; w < WAYS; w++) begin
      aged[w]  = act[w] ? rrpv_q[w] + add : rrpv_q[w];
      distv[w] = act[w] && (aged[w] == RRPV_DISTANT);
    end
    hit_way  = '0;
    inv_way  = '0;
    dist_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w])  hit_way  = WAY_W'(w);
      if (invv[w])  inv_way  = WAY_W'(w);
      if (distv[w]) dist_way = WAY_W'(w);
    end
    vic = any_inv ? inv_way : dist_way;

    vld_new  = vld_q;
    rrpv_new = rrpv_q;
    tag_new  = tag_q;
    if (any_hit) begin
      rrpv_new[hit_way] = RRPV_NEAR;
    end else begin
      if (!any_inv) rrpv_new = aged;
      vld_new[vic]  = 1'b1;
      tag_new[vic]  = tag_r;
      rrpv_new[vic] = ins_rrpv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icnt_r <= '0;
    end else if (cmd.upd_go && !any_hit) begin
      icnt_r <= icnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.upd_go) begin
      hit         <= any_hit;
      way         <= WAY_OUT_W'(32'(any_hit ? hit_way : vic));
      evicted     <= !any_hit && !any_inv;
      evicted_tag <= (!any_hit && !any_inv) ? TAG_IN_W'(tag_q[vic]) : '0;
    end
  end

endmodule

FILE: rtl/brrip_cache_replacement.sv
// ----------------------------------------------------------------------------
// brrip_cache_replacement
// Set-associative tag store with bimodal RRIP replacement.
// ----------------------------------------------------------------------------
// Each input word is one access (set, tag); each output word reports hit,
// way used, and the evicted tag if a valid line was replaced. After reset the
// block sweeps the set memory once, one set per cycle, with in_tready held low
// throughout. After that an access moves from accept to result in steps:
// it is latched and the set quotient estimated, then the set index is reduced
// and the set row read from the single-port set memory, then the row is
// updated and the result register loaded. The next word is taken
// the cycle after the update, even if the previous result is still waiting on
// out_tready; only the update cycle stalls until the result register frees.
// Write configuration only while idle. active_ways 0 acts as 1, above WAYS as
// WAYS; bimodal_period 0 acts as 1, above 1024 as 1024.
// ----------------------------------------------------------------------------
module brrip_cache_replacement #(
  parameter int SETS     = 1024,
  parameter int WAYS     = 4,
  parameter int TAG_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // access word
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [brrip_pkg::IN_DATA_W-1:0]       in_tdata,   // set_index, tag_value
  // result word
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [brrip_pkg::OUT_DATA_W-1:0]      out_tdata,  // hit, way, evicted,
                                                            // evicted_tag
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [brrip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brrip_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import brrip_pkg::*;

  brrip_cmd_t  cmd;
  brrip_stat_t stat;

  logic                 res_hit;
  logic [WAY_OUT_W-1:0] res_way;
  logic                 res_evicted;
  logic [TAG_IN_W-1:0]  res_evicted_tag;

  brrip_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  brrip_dp #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .set_index   (in_tdata[SET_IN_W-1:0]),
    .tag_value   (in_tdata[SET_IN_W+TAG_IN_W-1:SET_IN_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .hit         (res_hit),
    .way         (res_way),
    .evicted     (res_evicted),
    .evicted_tag (res_evicted_tag)
  );

  // bits [0] hit, [2:1] way, [3] evicted, [23:4] evicted_tag
  assign out_tdata = {res_evicted_tag, res_evicted, res_way, res_hit};

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BRRIP tag store. A directed table covers cold
// fills, hits, full-set replacement, aging and the field extremes; random
// phases then sweep the way and period registers. Every result word is
// checked against a typed expectation or a local model of the replacement policy.
// ----------------------------------------------------------------------------
module testbench;
  import brrip_pkg::*;

  localparam int SETS     = 1024;
  localparam int WAYS     = 4;
  localparam int TAG_BITS = 20;
  localparam int LINES    = SETS * WAYS;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int DRAIN_PAD   = 6;
  localparam int LONG_HOLD   = 300;   // sink hold-off used to back up the pipe
  // Longest legal quiet stretch is the post-reset set sweep;
  // everything else (sender gaps, sink hold, drain pad) is well below it.
  localparam int QUIET_LIMIT = 5000;

  // in_tdata: set_idx [9:0], tag_val [29:10], zero pad [31:30]
  typedef struct packed {
    logic [IN_DATA_W-SET_IN_W-TAG_IN_W-1:0] pad;
    logic [TAG_IN_W-1:0]                    tag_val;
    logic [SET_IN_W-1:0]                    set_idx;
  } access_t;

  // out_tdata: hit [0], way [2:1], evicted [3], ev_tag [23:4]
  typedef struct packed {
    logic [TAG_IN_W-1:0]  ev_tag;
    logic                 evicted;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } result_t;

  typedef struct {
    access_t acc;
    bit      known;   // expectation typed into the row
    result_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_ACTIVE_WAYS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  brrip_cache_replacement #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // policy model state
  bit                    line_vld  [LINES];
  logic [RRPV_W-1:0]     line_rrpv [LINES];
  logic [TAG_IN_W-1:0]   line_tag  [LINES];
  logic [ICNT_W-1:0]     insert_count;
  logic [WAYS_REG_W-1:0] ways_reg;
  logic [PERIOD_W-1:0]   period_reg;

  result_t     pending_results [$];
  dir_row_t    directed_rows   [$];
  int unsigned mismatches    = 0;
  int unsigned hold_requests = 0;   // bumped by the sender, served by the sink
  int unsigned quiet_cycles  = 0;
  bit          sender_steady = 1'b0;

  // Phase settings. Include the clamped encodings (ways 0 and above WAYS,
  // period 0 and above 1024). Period drops from 1024 to 3 so the insert
  // counter sits past the new period end.
  int unsigned phase_ways   [NUM_PHASES] = '{1, 0, 7, 2, 4, 3, 5, 4};
  int unsigned phase_period [NUM_PHASES] = '{1, 0, 2047, 1024, 3, 2, 8, 5};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Policy model: lookup, fill, age, replace for one access.
  // --------------------------------------------------------------------------
  function automatic result_t brrip_lookup(input access_t acc);
    int unsigned       n_ways, period, base, victim, w;
    logic [RRPV_W-1:0] oldest, lift, ins_rrpv;
    bit                placed;
    result_t           r;
    n_ways = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : ways_reg;
    period = (period_reg == 0) ? 1 :
             (period_reg > MAX_PERIOD) ? MAX_PERIOD : period_reg;
    base   = acc.set_idx * WAYS;
    r      = '0;

    for (w = 0; w < n_ways; w++) begin
      if (line_vld[base + w] && line_tag[base + w] == acc.tag_val) begin
        line_rrpv[base + w] = RRPV_NEAR;
        r.hit = 1'b1;
        r.way = w[WAY_OUT_W-1:0];
        return r;
      end
    end

    // miss: lowest invalid active way first
    placed = 1'b0;
    victim = 0;
    for (w = 0; w < n_ways; w++)
      if (!placed && !line_vld[base + w]) begin
        victim = w;
        placed = 1'b1;
      end

    // full set: age until some line is distant, take the lowest such way
    if (!placed) begin
      oldest = RRPV_NEAR;
      for (w = 0; w < n_ways; w++)
        if (line_rrpv[base + w] > oldest) oldest = line_rrpv[base + w];
      lift = RRPV_DISTANT - oldest;
      for (w = 0; w < n_ways; w++)
        line_rrpv[base + w] = line_rrpv[base + w] + lift;
      for (w = 0; w < n_ways; w++)
        if (!placed && line_rrpv[base + w] == RRPV_DISTANT) begin
          victim = w;
          placed = 1'b1;
        end
      r.evicted = 1'b1;
      r.ev_tag  = line_tag[base + victim];
    end

    // bimodal insert: long on the first miss of each period
    ins_rrpv = (insert_count == 0) ? RRPV_LONG : RRPV_DISTANT;
    if (insert_count + 1 >= period) insert_count = '0;
    else insert_count = insert_count + 1'b1;

    line_vld[base + victim]  = 1'b1;
    line_tag[base + victim]  = acc.tag_val;
    line_rrpv[base + victim] = ins_rrpv;
    r.way = victim[WAY_OUT_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_access_row(input int unsigned s, input int unsigned t,
                                         input bit known = 1'b0, input bit h = 1'b0,
                                         input int unsigned w = 0, input bit ev = 1'b0,
                                         input int unsigned et = 0);
    dir_row_t row;
    row.acc          = '0;
    row.acc.set_idx  = s[SET_IN_W-1:0];
    row.acc.tag_val  = t[TAG_IN_W-1:0];
    row.known        = known;
    row.want         = '0;
    row.want.hit     = h;
    row.want.way     = w[WAY_OUT_W-1:0];
    row.want.evicted = ev;
    row.want.ev_tag  = et[TAG_IN_W-1:0];
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    mismatches++;
  endtask

  // Offer one word and wait for the handshake; predict at the accepting edge.
  // Called and returns on a rising edge.
  task automatic offer_access(input access_t acc, input bit known, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= acc;
    do @(posedge clk); while (!in_tready);
    predicted = brrip_lookup(acc);
    pending_results.push_back(known ? want : predicted);
  endtask

  // Sender pause: every expected word is back and the pipe has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Both registers on consecutive edges; write enable stays high across them.
  task automatic program_policy(input int unsigned ways, input int unsigned period);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ACTIVE_WAYS;
    cfg_wdata <= CFG_DATA_W'(ways);
    @(posedge clk);
    cfg_index <= CFG_BIMODAL_PERIOD;
    cfg_wdata <= CFG_DATA_W'(period);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ways_reg   = ways[WAYS_REG_W-1:0];
    period_reg = period[PERIOD_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, directed table, then random phases.
  // --------------------------------------------------------------------------
  initial begin : sender
    int unsigned set_pool [4];
    int unsigned tag_pool [8];
    int unsigned i, p, n;
    access_t     acc;
    result_t     none;

    for (i = 0; i < LINES; i++) begin
      line_vld[i]  = 1'b0;
      line_rrpv[i] = RRPV_DISTANT;
      line_tag[i]  = '0;
    end
    insert_count = '0;
    ways_reg     = ACTIVE_WAYS_RST;
    period_reg   = BIMODAL_PERIOD_RST;
    none         = '0;

    // Reset defaults: 4 ways, period 8. Cold fills walk ways 0..3.
    add_access_row(0, 0, 1'b1, 1'b0, 0);              // cold fill, way 0
    add_access_row(0, 0, 1'b1, 1'b1, 0);              // back-to-back same set hit
    add_access_row(1023, 'hFFFFF, 1'b1, 1'b0, 0);     // top set, all-ones tag
    add_access_row(1023, 'hFFFFF, 1'b1, 1'b1, 0);
    add_access_row(0, 1, 1'b1, 1'b0, 1);
    add_access_row(0, 2, 1'b1, 1'b0, 2);
    add_access_row(0, 3, 1'b1, 1'b0, 3);
    add_access_row(0, 4);                             // full set, first distant way goes
    add_access_row(0, 4);
    add_access_row(0, 0);                             // pull every way to near
    add_access_row(0, 2);
    add_access_row(0, 3);
    add_access_row(0, 5);                             // no distant line: set ages first
    add_access_row(1023, 0);
    add_access_row(1023, 'h55555);
    add_access_row(1023, 'hAAAAA);
    add_access_row(1023, 'h0F0F0);
    add_access_row(1023, 'hFFFFF);
    add_access_row('h155, 'hAAAAA);
    add_access_row('h2AA, 'h55555);

    for (i = 0; i < 4; i++) set_pool[i] = $urandom_range(0, SETS - 1);
    for (i = 0; i < 8; i++) tag_pool[i] = $urandom_range(0, 'hFFFFF);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // in_tready stays low through the post-reset sweep; the handshake wait
    // absorbs it.
    for (i = 0; i < directed_rows.size(); i++)
      offer_access(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].want);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      program_policy(phase_ways[p], phase_period[p]);
      sender_steady = (p % 2 == 1);
      // refresh a couple of tags so old lines linger while new ones arrive
      tag_pool[$urandom_range(0, 7)] = $urandom_range(0, 'hFFFFF);
      tag_pool[$urandom_range(0, 7)] = $urandom_range(0, 'hFFFFF);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // one full stop mid-phase, and one long sink hold-off with the
        // sender pushing back to back so the input stalls
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
        if (p == 3 && n == 10) hold_requests++;
        acc = '0;
        acc.set_idx = SET_IN_W'(($urandom_range(0, 99) < 85) ?
                                set_pool[$urandom_range(0, 3)] :
                                $urandom_range(0, SETS - 1));
        acc.tag_val = TAG_IN_W'(($urandom_range(0, 99) < 80) ?
                                tag_pool[$urandom_range(0, 7)] :
                                $urandom_range(0, 'hFFFFF));
        offer_access(acc, 1'b0, none);
      end
    end

    wait_drained();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink: random back-pressure, stretches with none, one long hold on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left, mode_left, holds_served;
    bit          steady;
    stall_left   = 0;
    mode_left    = 0;
    holds_served = 0;
    steady       = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 2) == 0);
        mode_left = 100;
      end
      mode_left--;
      if (!steady && stall_left == 0 && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest pending expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want, seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, 32'(seen));
      end else begin
        want = pending_results.pop_front();
        if (seen.hit !== want.hit)
          report_mismatch("hit", 32'(want.hit), 32'(seen.hit));
        if (seen.way !== want.way)
          report_mismatch("way", 32'(want.way), 32'(seen.way));
        if (seen.evicted !== want.evicted)
          report_mismatch("evicted", 32'(want.evicted), 32'(seen.evicted));
        if (seen.ev_tag !== want.ev_tag)
          report_mismatch("evicted_tag", 32'(want.ev_tag), 32'(seen.ev_tag));
      end
    end
  end

  // Watchdog: no word moving on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
